>>> rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Types and constants shared by the TCP client connection control block.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam logic [1:0] FUNC_CONNECT = 2'd0;
    localparam logic [1:0] FUNC_CLOSE   = 2'd1;
    localparam logic [1:0] FUNC_SEGMENT = 2'd2;

    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;

    localparam logic [1:0] STATUS_HANDLED = 2'd0;
    localparam logic [1:0] STATUS_DROPPED = 2'd1;
    localparam logic [1:0] STATUS_REFUSED = 2'd2;

    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [15:0] WIN_MAX       = 16'hffff;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] initial_seq;
        logic [31:0] src_ip;
        logic [15:0] seg_sport;
        logic [15:0] seg_dport;
        logic [31:0] seq_num;
        logic [7:0]  seg_flags;
        logic [3:0]  data_offset_words;
        logic [15:0] seg_bytes;
        logic [15:0] peer_window;
        logic [17:0] rcv_free;
    } tcf_in_t;

    typedef struct packed {
        logic        send_segment;
        logic [7:0]  out_flags;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [15:0] out_src_port;
        logic [15:0] out_dst_port;
        logic [31:0] out_dst_ip;
        logic [15:0] out_window;
        logic [15:0] deliver_len;
        logic [2:0]  conn_state;
        logic [1:0]  status;
    } tcf_out_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] initial_seq;
        logic [31:0] src_ip;
        logic [15:0] seg_sport;
        logic [15:0] seg_dport;
        logic [31:0] seq_num;
        logic        fin;
        logic        syn;
        logic        rst;
        logic        ack;
        logic        truncated;
        logic        hdr_over;
        logic [15:0] plen;
        logic [15:0] win0;
        logic [15:0] winp;
    } tcf_cmd_t;

    typedef struct packed {
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] remote_ip;
    } tcf_cfg_t;

endpackage

>>> rtl/tcf_front.sv
// ----------------------------------------------------------------------------
// tcf_front
// Classifies an incoming transaction: flag decode, length checks, windows.
// ----------------------------------------------------------------------------
module tcf_front (
    input  tcf_pkg::tcf_in_t  in_data,
    output tcf_pkg::tcf_cmd_t cmd
);
    import tcf_pkg::*;

    logic [15:0] hlen;
    logic [17:0] rem;

    always_comb begin
        hlen = {10'd0, in_data.data_offset_words, 2'b00};
        cmd.func        = in_data.func;
        cmd.initial_seq = in_data.initial_seq;
        cmd.src_ip      = in_data.src_ip;
        cmd.seg_sport   = in_data.seg_sport;
        cmd.seg_dport   = in_data.seg_dport;
        cmd.seq_num     = in_data.seq_num;
        cmd.fin         = |(in_data.seg_flags & FL_FIN);
        cmd.syn         = |(in_data.seg_flags & FL_SYN);
        cmd.rst         = |(in_data.seg_flags & FL_RST);
        cmd.ack         = |(in_data.seg_flags & FL_ACK);
        cmd.truncated   = in_data.seg_bytes < MIN_HDR_BYTES;
        cmd.hdr_over    = in_data.seg_bytes < hlen;
        cmd.plen        = in_data.seg_bytes - hlen;
        cmd.win0        = (in_data.rcv_free[17:16] != 2'd0) ? WIN_MAX
                                                             : in_data.rcv_free[15:0];
        rem = (in_data.rcv_free > {2'd0, cmd.plen})
              ? in_data.rcv_free - {2'd0, cmd.plen} : 18'd0;
        cmd.winp        = (rem[17:16] != 2'd0) ? WIN_MAX : rem[15:0];
    end

endmodule

>>> rtl/tcf_queue.sv
// ----------------------------------------------------------------------------
// tcf_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
module tcf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  tcf_pkg::tcf_cmd_t  wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output tcf_pkg::tcf_cmd_t  rd_data
);
    import tcf_pkg::*;

    tcf_cmd_t    mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_wr, do_rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/tcf_back.sv
// ----------------------------------------------------------------------------
// tcf_back
// Connection state, sequence tracking and the registered result stage.
// ----------------------------------------------------------------------------
module tcf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcf_pkg::tcf_cfg_t  cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tcf_pkg::tcf_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output tcf_pkg::tcf_out_t  m_data
);
    import tcf_pkg::*;

    localparam logic [2:0] ST_CLOSED      = 3'd0;
    localparam logic [2:0] ST_SYN_SENT    = 3'd1;
    localparam logic [2:0] ST_ESTABLISHED = 3'd2;
    localparam logic [2:0] ST_CLOSE_WAIT  = 3'd3;
    localparam logic [2:0] ST_FIN_WAIT_1  = 3'd4;
    localparam logic [2:0] ST_FIN_WAIT_2  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        in_table_reg, in_table_next;
    logic [31:0] iss_reg, iss_next;
    logic [31:0] irs_reg, irs_next;
    logic [31:0] snr_reg, snr_next;
    logic [31:0] rnr_reg, rnr_next;
    tcf_cfg_t    lat_reg, lat_next;
    logic        valid_reg;
    tcf_out_t    out_reg, res;

    logic [31:0] ack_cur;
    logic        in_order;
    logic        matched;
    logic        take;

    assign take      = cmd_valid && cmd_ready;
    assign cmd_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_data    = out_reg;
    assign ack_cur   = irs_reg + rnr_reg;
    assign in_order  = cmd.seq_num == ack_cur;
    assign matched   = in_table_reg && cmd.src_ip == lat_reg.remote_ip
                       && cmd.seg_sport == lat_reg.remote_port
                       && cmd.seg_dport == lat_reg.local_port;

    always_comb begin
        state_next    = state_reg;
        in_table_next = in_table_reg;
        iss_next      = iss_reg;
        irs_next      = irs_reg;
        snr_next      = snr_reg;
        rnr_next      = rnr_reg;
        lat_next      = lat_reg;
        res           = '0;
        unique case (cmd.func)
            FUNC_CONNECT: begin
                lat_next      = cfg;
                iss_next      = cmd.initial_seq;
                in_table_next = 1'b1;
                state_next    = ST_SYN_SENT;
                res.send_segment = 1'b1;
                res.out_flags    = FL_SYN;
                res.out_seq      = cmd.initial_seq;
                res.out_src_port = cfg.local_port;
                res.out_dst_port = cfg.remote_port;
                res.out_dst_ip   = cfg.remote_ip;
                res.out_window   = cmd.win0;
            end
            FUNC_CLOSE: begin
                state_next = ST_FIN_WAIT_1;
                snr_next   = snr_reg + 32'd1;
                res.send_segment = 1'b1;
                res.out_flags    = FL_FIN;
                res.out_seq      = iss_reg + snr_next;
                res.out_ack      = ack_cur;
                res.out_src_port = lat_reg.local_port;
                res.out_dst_port = lat_reg.remote_port;
                res.out_dst_ip   = lat_reg.remote_ip;
                res.out_window   = cmd.win0;
            end
            FUNC_SEGMENT: begin
                if (cmd.truncated) begin
                    res.status = STATUS_DROPPED;
                end else if (!matched) begin
                    res.send_segment = 1'b1;
                    res.out_flags    = cmd.syn ? (FL_RST | FL_ACK) : FL_RST;
                    res.out_ack      = cmd.seq_num + 32'd1;
                    res.out_src_port = cmd.seg_dport;
                    res.out_dst_port = cmd.seg_sport;
                    res.out_dst_ip   = cmd.src_ip;
                    res.status       = STATUS_REFUSED;
                end else begin
                    res.out_window = cmd.win0;
                    unique case (state_reg)
                        ST_SYN_SENT: begin
                            if (cmd.ack && cmd.syn) begin
                                state_next = ST_ESTABLISHED;
                                irs_next   = cmd.seq_num;
                                rnr_next   = 32'd1;
                                snr_next   = 32'd1;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_ACK;
                                res.out_seq      = iss_reg + 32'd1;
                                res.out_ack      = cmd.seq_num + 32'd1;
                            end else if (cmd.ack && cmd.rst) begin
                                state_next    = ST_CLOSED;
                                in_table_next = 1'b0;
                            end
                        end
                        ST_ESTABLISHED: begin
                            if (!in_order || (!cmd.fin && cmd.hdr_over)) begin
                                state_next    = ST_CLOSED;
                                in_table_next = 1'b0;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_RST;
                            end else if (cmd.fin) begin
                                rnr_next   = rnr_reg + 32'd1;
                                state_next = ST_CLOSE_WAIT;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_FIN | FL_ACK;
                                res.out_seq      = iss_reg + snr_reg;
                                res.out_ack      = ack_cur + 32'd1;
                            end else if (cmd.plen != 16'd0) begin
                                rnr_next = rnr_reg + {16'd0, cmd.plen};
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_ACK;
                                res.out_seq      = iss_reg + snr_reg;
                                res.out_ack      = ack_cur + {16'd0, cmd.plen};
                                res.out_window   = cmd.winp;
                                res.deliver_len  = cmd.plen;
                            end
                        end
                        ST_CLOSE_WAIT: begin
                            state_next    = ST_CLOSED;
                            in_table_next = 1'b0;
                            if (!in_order || !cmd.ack) begin
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_RST;
                            end
                        end
                        ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
                            if (!in_order || (state_reg == ST_FIN_WAIT_1 && !cmd.ack)) begin
                                state_next    = ST_CLOSED;
                                in_table_next = 1'b0;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_RST;
                            end else if (cmd.fin) begin
                                rnr_next      = rnr_reg + 32'd1;
                                state_next    = ST_CLOSED;
                                in_table_next = 1'b0;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_ACK;
                                res.out_seq      = iss_reg + snr_reg;
                                res.out_ack      = ack_cur + 32'd1;
                            end else if (state_reg == ST_FIN_WAIT_1) begin
                                state_next = ST_FIN_WAIT_2;
                            end else begin
                                state_next    = ST_CLOSED;
                                in_table_next = 1'b0;
                                res.send_segment = 1'b1;
                                res.out_flags    = FL_RST;
                            end
                        end
                        default: begin
                            state_next    = ST_CLOSED;
                            in_table_next = 1'b0;
                            res.send_segment = 1'b1;
                            res.out_flags    = FL_RST;
                        end
                    endcase
                    if (res.send_segment) begin
                        res.out_src_port = lat_reg.local_port;
                        res.out_dst_port = lat_reg.remote_port;
                        res.out_dst_ip   = lat_reg.remote_ip;
                    end else begin
                        res.out_window = 16'd0;
                    end
                end
            end
            default: begin
            end
        endcase
        res.conn_state = state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLOSED;
            in_table_reg <= 1'b0;
            iss_reg      <= 32'd0;
            irs_reg      <= 32'd0;
            snr_reg      <= 32'd0;
            rnr_reg      <= 32'd0;
            lat_reg      <= '0;
            valid_reg    <= 1'b0;
        end else begin
            if (take) begin
                state_reg    <= state_next;
                in_table_reg <= in_table_next;
                iss_reg      <= iss_next;
                irs_reg      <= irs_next;
                snr_reg      <= snr_next;
                rnr_reg      <= rnr_next;
                lat_reg      <= lat_next;
                valid_reg    <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res;
        end
    end

endmodule

>>> rtl/tcp_client_connection_fsm_core.sv
// ----------------------------------------------------------------------------
// tcp_client_connection_fsm_core
// Single-connection TCP client control block with APB register port.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  input    | s_valid / s_ready   | s_data  (tcf_in_t)
//  result   | m_valid / m_ready   | m_data  (tcf_out_t)
//  config   | psel/penable/pwrite | paddr, pwdata, prdata
//
//  One transaction per cycle sustained while m_ready stays high; a result passes
//  the queue write, then the back-end result register. Throughput is set by the
//  connection update in the back end.
//  Synchronous active-low reset clears state, queue and result valid.
//  A stalled result holds the back end; the two-entry queue absorbs input.
module tcp_client_connection_fsm_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcf_pkg::tcf_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcf_pkg::tcf_out_t  m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tcf_pkg::*;

    localparam logic [1:0] REG_LOCAL_PORT  = 2'd0;
    localparam logic [1:0] REG_REMOTE_PORT = 2'd1;
    localparam logic [1:0] REG_REMOTE_IP   = 2'd2;

    tcf_cfg_t cfg_reg;
    tcf_cmd_t front_cmd, q_cmd;
    logic     q_valid, q_ready;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_LOCAL_PORT:  cfg_reg.local_port  <= pwdata[15:0];
                REG_REMOTE_PORT: cfg_reg.remote_port <= pwdata[15:0];
                REG_REMOTE_IP:   cfg_reg.remote_ip   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_LOCAL_PORT:  prdata = {16'd0, cfg_reg.local_port};
            REG_REMOTE_PORT: prdata = {16'd0, cfg_reg.remote_port};
            REG_REMOTE_IP:   prdata = cfg_reg.remote_ip;
            default:         prdata = 32'd0;
        endcase
    end

    tcf_front u_front (
        .in_data (s_data),
        .cmd     (front_cmd)
    );

    tcf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    tcf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
